[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the WebSocket deframer.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge of clk, switched off while rst is high.
`define WSDF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define WSDF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define WSDF_ASSERT(label, prop, msg)
`define WSDF_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[rtl/core/wsdf_pkg.sv]
// Types and constants of the WebSocket frame deframer.
// Used by the channel interfaces and by the top level; depends on nothing.
package wsdf_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 32;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [3:0]        opcode_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_PROTO = 2'd2,
    KIND_BIG   = 2'd3
  } kind_t;

  // Resolved message types; also the encoding of the open fragment.
  localparam logic [1:0] MT_CONTROL = 2'd0;
  localparam logic [1:0] MT_TEXT    = 2'd1;
  localparam logic [1:0] MT_BINARY  = 2'd2;

  // Opcodes that the parser treats specially.
  localparam opcode_t OP_CONT  = 4'h0;
  localparam opcode_t OP_TEXT  = 4'h1;
  localparam opcode_t OP_BIN   = 4'h2;
  localparam opcode_t OP_RSVD3 = 4'h3;
  localparam opcode_t OP_RSVD7 = 4'h7;
  localparam opcode_t OP_CLOSE = 4'h8;
  localparam opcode_t OP_RSVDB = 4'hb;

  // Seven-bit length codes.
  localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
  localparam logic [6:0] LEN7_EXT16    = 7'd126;
  localparam logic [6:0] LEN7_EXT64    = 7'd127;

  localparam byte_t RSV_MASK = 8'h70;

  localparam len_t MAX_PAYLOAD_RESET = 32'd1048576;

endpackage

[rtl/core/wsdf_channels.sv]
// Valid/ready channel interfaces of the WebSocket frame deframer.
// Depends on wsdf_pkg.

interface wsdf_rx_if import wsdf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface wsdf_res_if import wsdf_pkg::*; ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  byte_t      data;
  opcode_t    opcode;
  logic [1:0] message_type;
  logic       fin;
  logic       last;

  modport source (output valid, output kind, output data, output opcode,
                  output message_type, output fin, output last, input ready);
  modport sink   (input valid, input kind, input data, input opcode,
                  input message_type, input fin, input last, output ready);
endinterface

interface wsdf_cfg_if import wsdf_pkg::*; ();
  logic valid;
  logic ready;
  len_t max_payload_bytes;

  modport source (output valid, output max_payload_bytes, input ready);
  modport sink   (input valid, input max_payload_bytes, output ready);
endinterface

[rtl/core/websocket_frame_deframer.sv]
// WebSocket frame deframer, client-to-server direction. It takes one stream byte per
// transaction on rx and can accept a new byte in every clock cycle unless a result held
// on res stalls it; a byte is caught in an input register, goes through a single pass of
// header parsing and unmasking, and any result lands in the output register on res. The
// rate of one byte per cycle, while res is not stalled, is set by that single parsing
// stage, which holds all frame state and updates it once per byte. Each frame gives one
// result per payload byte, or one empty-frame result for a zero-length frame. A protocol
// violation or an extended length above max_payload_bytes gives one error result with
// last set; after it, or after a complete close frame, bytes are still taken but give
// nothing until reset. max_payload_bytes (reset 1048576) is to be written through cfg
// only while the block is idle; the block itself does not enforce this.
// Depends on wsdf_pkg, wsdf_channels and assert_macros.svh.
`include "assert_macros.svh"

module websocket_frame_deframer import wsdf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  wsdf_rx_if.sink        rx,
  wsdf_res_if.source     res,
  wsdf_cfg_if.sink       cfg
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_SIZE = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // Input register.
  logic   in_vld;
  byte_t  in_byte;

  // Frame state.
  phase_t     phase, phase_next;
  logic [2:0] cnt, cnt_next;
  byte_t      fhb, fhb_next;
  logic       len64, len64_next;
  logic       hi_nz, hi_nz_next;
  len_t       len, len_next;
  len_t       key, key_next;
  logic [1:0] ofs, ofs_next;
  logic       dead, dead_next;
  len_t       max_len;

  // Output register.
  logic       out_vld;
  kind_t      out_kind;
  byte_t      out_data;
  opcode_t    out_opcode;
  logic [1:0] out_mtype;
  logic       out_fin;
  logic       out_last;

  // Result of the current pass.
  logic       has_res;
  kind_t      res_kind;
  byte_t      res_data;
  logic [1:0] res_mtype;
  logic       res_last;

  logic       proc_go;
  opcode_t    cur_op;
  logic       cur_fin;
  logic [1:0] cur_type;
  logic [6:0] len7;
  logic       bad;

  assign proc_go  = in_vld && (!out_vld || res.ready);
  assign rx.ready = !in_vld || proc_go;
  assign cfg.ready = 1'b1;

  assign res.valid        = out_vld;
  assign res.kind         = out_kind;
  assign res.data         = out_data;
  assign res.opcode       = out_opcode;
  assign res.message_type = out_mtype;
  assign res.fin          = out_fin;
  assign res.last         = out_last;

  assign cur_op  = fhb[3:0];
  assign cur_fin = fhb[7];
  assign len7    = in_byte[6:0];

  always_comb begin
    if (cur_op >= OP_CLOSE) begin
      cur_type = MT_CONTROL;
    end else if (cur_op == OP_TEXT) begin
      cur_type = MT_TEXT;
    end else if (cur_op == OP_BIN) begin
      cur_type = MT_BINARY;
    end else if (cur_op == OP_CONT) begin
      cur_type = ofs;
    end else begin
      cur_type = MT_CONTROL;
    end
  end

  // Header checks on the second header byte.
  always_comb begin
    bad = 1'b0;
    if (!in_byte[7]) bad = 1'b1;
    if ((fhb & RSV_MASK) != '0) bad = 1'b1;
    if ((cur_op >= OP_RSVD3 && cur_op <= OP_RSVD7) || cur_op >= OP_RSVDB) bad = 1'b1;
    if (cur_op >= OP_CLOSE && len7 > LEN7_CTRL_MAX) bad = 1'b1;
    if (cur_op >= OP_CLOSE && !cur_fin) bad = 1'b1;
    if (ofs != MT_CONTROL && (cur_op == OP_TEXT || cur_op == OP_BIN)) bad = 1'b1;
    if (ofs == MT_CONTROL && cur_op == OP_CONT) bad = 1'b1;
  end

  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    fhb_next   = fhb;
    len64_next = len64;
    hi_nz_next = hi_nz;
    len_next   = len;
    key_next   = key;
    ofs_next   = ofs;
    dead_next  = dead;
    has_res    = 1'b0;
    res_kind   = KIND_DATA;
    res_data   = '0;
    res_mtype  = MT_CONTROL;
    res_last   = 1'b0;

    if (proc_go && !dead) begin
      case (phase)
        PH_HDR0: begin
          fhb_next   = in_byte;
          phase_next = PH_HDR1;
        end
        PH_HDR1: begin
          if (bad) begin
            dead_next = 1'b1;
            has_res   = 1'b1;
            res_kind  = KIND_PROTO;
            res_last  = 1'b1;
          end else begin
            if ((cur_op == OP_TEXT || cur_op == OP_BIN) && !cur_fin) begin
              ofs_next = cur_op[1:0];
            end
            len64_next = (len7 == LEN7_EXT64);
            hi_nz_next = 1'b0;
            cnt_next   = '0;
            if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
              len_next   = '0;
              phase_next = PH_SIZE;
            end else begin
              len_next   = {{(LEN_W-7){1'b0}}, len7};
              phase_next = PH_MASK;
            end
          end
        end
        PH_SIZE: begin
          // Bytes pushed out of the low word are kept only as a non-zero mark.
          len_next   = {len[LEN_W-BYTE_W-1:0], in_byte};
          hi_nz_next = hi_nz || (len[LEN_W-1 -: BYTE_W] != '0);
          cnt_next   = cnt + 3'd1;
          if (cnt_next == (len64 ? 3'd0 : 3'd2)) begin
            if (hi_nz_next || len_next > max_len) begin
              dead_next = 1'b1;
              has_res   = 1'b1;
              res_kind  = KIND_BIG;
              res_last  = 1'b1;
            end else begin
              cnt_next   = '0;
              phase_next = PH_MASK;
            end
          end
        end
        PH_MASK: begin
          key_next = {key[LEN_W-BYTE_W-1:0], in_byte};
          cnt_next = cnt + 3'd1;
          if (cnt_next == 3'd4) begin
            cnt_next = '0;
            if (len == '0) begin
              has_res   = 1'b1;
              res_kind  = KIND_EMPTY;
              res_mtype = cur_type;
              res_last  = 1'b1;
              if (cur_op == OP_CLOSE) dead_next = 1'b1;
              if (cur_op == OP_CONT && cur_fin) ofs_next = MT_CONTROL;
              phase_next = PH_HDR0;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          // The key rotates so that its top byte always masks the next byte.
          key_next  = {key[LEN_W-BYTE_W-1:0], key[LEN_W-1 -: BYTE_W]};
          len_next  = len - len_t'(1);
          has_res   = 1'b1;
          res_kind  = KIND_DATA;
          res_data  = in_byte ^ key[LEN_W-1 -: BYTE_W];
          res_mtype = cur_type;
          res_last  = (len == len_t'(1));
          if (res_last) begin
            if (cur_op == OP_CLOSE) dead_next = 1'b1;
            if (cur_op == OP_CONT && cur_fin) ofs_next = MT_CONTROL;
            phase_next = PH_HDR0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld  <= 1'b0;
      out_vld <= 1'b0;
      phase   <= PH_HDR0;
      cnt     <= '0;
      ofs     <= MT_CONTROL;
      dead    <= 1'b0;
      max_len <= MAX_PAYLOAD_RESET;
    end else begin
      if (rx.ready) begin
        in_vld <= rx.valid;
      end
      if (proc_go) begin
        out_vld <= has_res;
      end else if (res.ready) begin
        out_vld <= 1'b0;
      end
      if (cfg.valid) begin
        max_len <= cfg.max_payload_bytes;
      end
      phase <= phase_next;
      cnt   <= cnt_next;
      ofs   <= ofs_next;
      dead  <= dead_next;
    end
    if (rx.ready && rx.valid) begin
      in_byte <= rx.byte_in;
    end
    fhb   <= fhb_next;
    len64 <= len64_next;
    hi_nz <= hi_nz_next;
    len   <= len_next;
    key   <= key_next;
    if (proc_go && has_res) begin
      out_kind   <= res_kind;
      out_data   <= res_data;
      out_opcode <= cur_op;
      out_mtype  <= res_mtype;
      out_fin    <= cur_fin;
      out_last   <= res_last;
    end
  end

  `WSDF_ASSERT(a_dead_sticks, dead |=> dead, "deframer left the dead state without reset")
  `WSDF_ASSERT(a_err_kills, proc_go && has_res && (res_kind == KIND_PROTO || res_kind == KIND_BIG) |=> dead, "error result did not make the deframer dead")
  `WSDF_ASSERT(a_data_len, phase == PH_DATA |-> len != '0, "payload phase entered with no bytes left")
  `WSDF_ASSERT(a_nondata_last, out_vld && out_kind != KIND_DATA |-> out_last && out_data == '0, "non-payload result without last or with data")

endmodule

[bench/tb_websocket_frame_deframer.sv]
// Self-checking bench for the WebSocket frame deframer: masked client frames are streamed in
// byte by byte and every deframed result is checked against a bench-side model of the parser.
// Depends on wsdf_pkg, the wsdf channel interfaces and the deframer RTL.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
  import wsdf_pkg::*;

  localparam opcode_t OP_PING = 4'h9;
  localparam opcode_t OP_PONG = 4'ha;
  localparam opcode_t OP_RSVDF = 4'hf;
  localparam int unsigned STREAM_TARGET = 1500;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef enum logic [2:0] {PS_HDR0, PS_HDR1, PS_EXTLEN, PS_KEY, PS_PAYLOAD} parse_state_t;
  typedef enum int unsigned {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;
  typedef enum int unsigned {
    END_NO_MASK, END_RSV, END_RSVD_OP, END_CTRL_LONG, END_CTRL_FRAG,
    END_NESTED, END_ORPHAN, END_BIG16, END_BIG64, END_CLOSE
  } stream_end_t;

  typedef struct packed {
    kind_t      kind;
    byte_t      data;
    opcode_t    opcode;
    logic [1:0] message_type;
    logic       fin;
    logic       last;
  } deframe_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wsdf_rx_if  rx_ch ();
  wsdf_res_if res_ch ();
  wsdf_cfg_if cfg_ch ();

  websocket_frame_deframer DUT (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .res(res_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state as the bench sees it.
  parse_state_t ps_state = PS_HDR0;
  int unsigned  ps_count = 0;
  byte_t        ps_hdr0 = '0;
  logic [6:0]   ps_len7 = '0;
  logic [63:0]  ps_ext_len = '0;
  len_t         ps_left = '0;
  logic [31:0]  ps_key = '0;
  logic [1:0]   ps_key_pos = '0;
  logic [1:0]   ps_open_type = MT_CONTROL;
  logic         ps_dead = 1'b0;
  len_t         ps_max_len = MAX_PAYLOAD_RESET;

  byte_t           stream_bytes[$];
  deframe_result_t deframe_expect[$];

  int unsigned bytes_sent = 0;
  int unsigned bytes_taken = 0;
  int unsigned frames_sent = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cfg_writes = 0;
  int unsigned quiet_cycles = 0;
  len_t        cfg_now = MAX_PAYLOAD_RESET;
  bit          byte_taken = 1'b0;
  bit          cfg_taken = 1'b0;
  int unsigned rx_gap = 0;
  int unsigned rx_calm = 0;
  int unsigned res_stall = 0;
  int unsigned res_calm = 0;

  function automatic logic [1:0] resolved_type();
    opcode_t op;
    op = ps_hdr0[3:0];
    if (op >= OP_CLOSE) return MT_CONTROL;
    if (op == OP_TEXT) return MT_TEXT;
    if (op == OP_BIN) return MT_BINARY;
    if (op == OP_CONT) return ps_open_type;
    return MT_CONTROL;
  endfunction

  function automatic void end_of_frame();
    if (ps_hdr0[3:0] == OP_CLOSE) ps_dead = 1'b1;
    if (ps_hdr0[3:0] == OP_CONT && ps_hdr0[7]) ps_open_type = MT_CONTROL;
    ps_state = PS_HDR0;
  endfunction

  // Advances the parser by one stream byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input byte_t b, output deframe_result_t r);
    opcode_t    op;
    logic [6:0] len7;
    bit         bad;
    int unsigned need;
    r = '0;
    op = ps_hdr0[3:0];
    r.opcode = op;
    r.fin = ps_hdr0[7];
    if (ps_dead) return 1'b0;
    case (ps_state)
      PS_HDR0: begin
        ps_hdr0 = b;
        ps_state = PS_HDR1;
        return 1'b0;
      end
      PS_HDR1: begin
        len7 = b[6:0];
        bad = !b[7] || ((ps_hdr0 & RSV_MASK) != '0)
              || (op >= OP_RSVD3 && op <= OP_RSVD7) || op >= OP_RSVDB
              || (op >= OP_CLOSE && (len7 > LEN7_CTRL_MAX || !ps_hdr0[7]))
              || (ps_open_type != MT_CONTROL && (op == OP_TEXT || op == OP_BIN))
              || (ps_open_type == MT_CONTROL && op == OP_CONT);
        if (bad) begin
          ps_dead = 1'b1;
          r.kind = KIND_PROTO;
          r.last = 1'b1;
          return 1'b1;
        end
        if ((op == OP_TEXT || op == OP_BIN) && !ps_hdr0[7]) ps_open_type = op[1:0];
        ps_len7 = len7;
        ps_count = 0;
        if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
          ps_ext_len = '0;
          ps_state = PS_EXTLEN;
        end else begin
          ps_ext_len = 64'(len7);
          ps_state = PS_KEY;
        end
        return 1'b0;
      end
      PS_EXTLEN: begin
        need = (ps_len7 == LEN7_EXT16) ? 2 : 8;
        ps_ext_len = {ps_ext_len[55:0], b};
        ps_count++;
        if (ps_count == need) begin
          if (ps_ext_len > {32'd0, ps_max_len}) begin
            ps_dead = 1'b1;
            r.kind = KIND_BIG;
            r.last = 1'b1;
            return 1'b1;
          end
          ps_count = 0;
          ps_state = PS_KEY;
        end
        return 1'b0;
      end
      PS_KEY: begin
        ps_key = {ps_key[23:0], b};
        ps_count++;
        if (ps_count == 4) begin
          ps_count = 0;
          ps_key_pos = '0;
          ps_left = ps_ext_len[31:0];
          if (ps_left == '0) begin
            r.kind = KIND_EMPTY;
            r.message_type = resolved_type();
            r.last = 1'b1;
            end_of_frame();
            return 1'b1;
          end
          ps_state = PS_PAYLOAD;
        end
        return 1'b0;
      end
      default: begin
        r.kind = KIND_DATA;
        r.data = b ^ ps_key[8*(3-int'(ps_key_pos)) +: 8];
        ps_key_pos++;
        ps_left--;
        r.message_type = resolved_type();
        r.last = (ps_left == '0);
        if (r.last) end_of_frame();
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Mostly back-to-back, some short pauses, a few long ones, and now and then a calm stretch.
  function automatic int unsigned pick_idle(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Results are checked before the byte of the same edge is predicted, so the order is fixed.
  always @(posedge clk) begin : monitor
    deframe_result_t want;
    deframe_result_t predicted;
    byte_taken = 1'b0;
    cfg_taken = 1'b0;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (deframe_expect.size() == 0) begin
          $error("unexpected result: kind %0d data %0h", res_ch.kind, res_ch.data);
          mismatches++;
        end else begin
          want = deframe_expect.pop_front();
          check_field("kind", 8'(want.kind), 8'(res_ch.kind));
          check_field("data", want.data, res_ch.data);
          check_field("opcode", 8'(want.opcode), 8'(res_ch.opcode));
          check_field("message_type", 8'(want.message_type), 8'(res_ch.message_type));
          check_field("fin", 8'(want.fin), 8'(res_ch.fin));
          check_field("last", 8'(want.last), 8'(res_ch.last));
          results_checked++;
        end
      end
      if (rx_ch.valid && rx_ch.ready) begin
        byte_taken = 1'b1;
        bytes_taken++;
        if (deframe_byte(rx_ch.byte_in, predicted)) deframe_expect.push_back(predicted);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        cfg_taken = 1'b1;
        ps_max_len = cfg_ch.max_payload_bytes;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin : byte_driver
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.byte_in <= '0;
    end else if (!(rx_ch.valid && !byte_taken)) begin
      if (rx_gap > 0) begin
        rx_ch.valid <= 1'b0;
        rx_gap--;
      end else if (stream_bytes.size() > 0) begin
        rx_ch.valid <= 1'b1;
        rx_ch.byte_in <= stream_bytes.pop_front();
        rx_gap = pick_idle(rx_calm);
      end else begin
        rx_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_ready
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (res_stall > 0) begin
      res_ch.ready <= 1'b0;
      res_stall--;
    end else begin
      res_ch.ready <= 1'b1;
      res_stall = pick_idle(res_calm);
    end
  end

  task automatic push_byte(input byte_t b);
    stream_bytes.push_back(b);
    bytes_sent++;
  endtask

  task automatic push_header(input opcode_t op, input logic fin, input logic [63:0] len,
                             input len_form_t form);
    push_byte({fin, 3'b000, op});
    case (form)
      LEN_SHORT: push_byte({1'b1, len[6:0]});
      LEN_EXT16: begin
        push_byte({1'b1, LEN7_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({1'b1, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
    endcase
  endtask

  // A negative fill gives random payload bytes.
  task automatic push_frame(input opcode_t op, input logic fin, input int unsigned len,
                            input len_form_t form, input logic [31:0] key, input int fill);
    push_header(op, fin, 64'(len), form);
    for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
    repeat (len) push_byte(fill < 0 ? byte_t'($urandom) : byte_t'(fill));
    frames_sent++;
  endtask

  task automatic push_data_frame(input opcode_t op, input logic fin);
    int unsigned len;
    int unsigned r;
    len_form_t   form;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(0, 12);
    else if (r < 90) len = $urandom_range(13, 40);
    else if (r < 97) len = $urandom_range(41, 125);
    else len = $urandom_range(126, 300);
    r = $urandom_range(0, 99);
    if (r < 60) form = LEN_SHORT;
    else if (r < 85) form = LEN_EXT16;
    else form = LEN_EXT64;
    if (len > LEN7_CTRL_MAX && form == LEN_SHORT) form = LEN_EXT16;
    // Extended lengths must stay within the limit, or the block would stop for good.
    if (form != LEN_SHORT && len > cfg_now) begin
      if (len <= LEN7_CTRL_MAX) form = LEN_SHORT;
      else len = cfg_now;
    end
    push_frame(op, fin, len, form, $urandom, -1);
  endtask

  task automatic push_control_frame();
    int unsigned len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 8);
    push_frame($urandom_range(0, 1) ? OP_PING : OP_PONG, 1'b1, len, LEN_SHORT, $urandom, -1);
  endtask

  task automatic push_message();
    opcode_t     first_op;
    int unsigned pieces;
    first_op = $urandom_range(0, 1) ? OP_TEXT : OP_BIN;
    pieces = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
    for (int i = 0; i < pieces; i++) begin
      if (i > 0 && $urandom_range(0, 3) == 0) push_control_frame();
      push_data_frame(i == 0 ? first_op : OP_CONT, i == pieces - 1);
    end
  endtask

  // One event that leaves the block dead; only one can occur per reset.
  task automatic push_stream_end(input stream_end_t how);
    opcode_t     op;
    logic        fin;
    logic [63:0] len;
    fin = 1'($urandom_range(0, 1));
    case (how)
      END_NO_MASK: begin
        push_byte({fin, 3'b000, ($urandom_range(0, 1) ? OP_TEXT : OP_BIN)});
        push_byte({1'b0, 7'($urandom)});
      end
      END_RSV: begin
        push_byte({1'b1, 3'($urandom_range(1, 7)), OP_TEXT});
        push_byte({1'b1, 7'($urandom_range(0, 125))});
      end
      END_RSVD_OP: begin
        if ($urandom_range(0, 1)) op = opcode_t'($urandom_range(OP_RSVD3, OP_RSVD7));
        else op = opcode_t'($urandom_range(OP_RSVDB, OP_RSVDF));
        push_header(op, fin, 64'($urandom_range(0, 125)), LEN_SHORT);
      end
      END_CTRL_LONG: begin
        push_byte({1'b1, 3'b000, opcode_t'($urandom_range(OP_CLOSE, OP_PONG))});
        push_byte({1'b1, ($urandom_range(0, 1) ? LEN7_EXT16 : LEN7_EXT64)});
      end
      END_CTRL_FRAG: begin
        push_header(opcode_t'($urandom_range(OP_CLOSE, OP_PONG)), 1'b0,
                    64'($urandom_range(0, 125)), LEN_SHORT);
      end
      END_NESTED: begin
        push_frame($urandom_range(0, 1) ? OP_TEXT : OP_BIN, 1'b0, $urandom_range(0, 4),
                   LEN_SHORT, $urandom, -1);
        push_header($urandom_range(0, 1) ? OP_TEXT : OP_BIN, fin,
                    64'($urandom_range(0, 125)), LEN_SHORT);
      end
      END_ORPHAN: push_header(OP_CONT, fin, 64'($urandom_range(0, 125)), LEN_SHORT);
      END_BIG16: begin
        // A sixteen-bit length cannot exceed a large limit; use the long form then.
        if (cfg_now < 32'd65535) begin
          push_header(OP_BIN, 1'b1, 64'($urandom_range(cfg_now + 1, 65535)), LEN_EXT16);
        end else begin
          push_header(OP_BIN, 1'b1, {32'($urandom) | 32'd1, 32'($urandom)}, LEN_EXT64);
        end
      end
      END_BIG64: begin
        if (cfg_now != '1 && $urandom_range(0, 1)) len = 64'(cfg_now) + 64'd1;
        else len = {32'($urandom) | 32'd1, 32'($urandom)};
        push_header(OP_TEXT, 1'b1, len, LEN_EXT64);
      end
      default: push_frame(OP_CLOSE, 1'b1, $urandom_range(0, 4), LEN_SHORT, $urandom, -1);
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (bytes_taken != bytes_sent || deframe_expect.size() != 0);
    // Header bytes give no result, so allow the pipeline to settle.
    repeat (4) @(negedge clk);
  endtask

  task automatic write_max_len(input len_t value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_payload_bytes <= value;
    do @(negedge clk); while (!cfg_taken);
    cfg_ch.valid <= 1'b0;
    cfg_now = value;
    cfg_writes++;
  endtask

  initial begin : stimulus
    stream_end_t how;
    int unsigned phase_no;
    int unsigned stream_items;
    len_t        next_max;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_payload_bytes = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Opening frames under the reset limit: all-ones payload through a zero key, an empty
    // binary fragment, a ping in between, and an empty final continuation with a short
    // extended length.
    push_frame(OP_TEXT, 1'b1, 1, LEN_SHORT, 32'h0000_0000, 255);
    push_frame(OP_BIN, 1'b0, 0, LEN_SHORT, 32'hffff_ffff, -1);
    push_frame(OP_PING, 1'b1, 1, LEN_SHORT, $urandom, 0);
    push_frame(OP_CONT, 1'b1, 0, LEN_EXT16, $urandom, -1);
    wait_drained();

    phase_no = 0;
    while (bytes_sent < STREAM_TARGET) begin
      case (phase_no)
        0: next_max = '0;
        1: next_max = '1;
        default: begin
          case ($urandom_range(0, 4))
            0: next_max = '0;
            1: next_max = '1;
            2: next_max = $urandom_range(0, 64);
            3: next_max = $urandom;
            default: next_max = MAX_PAYLOAD_RESET;
          endcase
        end
      endcase
      write_max_len(next_max);
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 4) == 0) push_control_frame();
        push_message();
      end
      wait_drained();
      phase_no++;
    end

    stream_items = bytes_sent;
    how = stream_end_t'($urandom_range(END_NO_MASK, END_CLOSE));
    push_stream_end(how);
    repeat (16) push_byte(byte_t'($urandom));
    wait_drained();
    repeat (12) @(negedge clk);

    $display("Streamed %0d bytes in %0d frames over %0d length-limit settings, %0d results checked.",
             stream_items, frames_sent, cfg_writes, results_checked);
    $display("The stream was ended by %s and followed by bytes the block must ignore.",
             how.name());
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/wsdf_pkg.sv
rtl/core/wsdf_channels.sv
rtl/core/websocket_frame_deframer.sv
bench/tb_websocket_frame_deframer.sv
